// ----- sv/vtff_pkg.sv -----
// Package for the vision target freshness filter.
// Holds the sequencer state type, the register index codes and the fixed-point widths.
// No dependencies.
package vtff_pkg;

  localparam int ALPHA_FRAC_BITS = 16;

  localparam int TIMEOUT_W = 16;
  localparam int TAU_W     = 24;
  localparam int DT_W      = 20;
  localparam int CFG_W     = 24;
  localparam int ANGLE_W   = 32;
  localparam int TICK_W    = 32;

  localparam int DIV_W   = TAU_W + 1;
  localparam int CNT_W   = $clog2(ALPHA_FRAC_BITS + 1);
  localparam int DIFF_W  = ANGLE_W + 1;
  localparam int PROD_W  = DIFF_W + ALPHA_FRAC_BITS + 1;
  localparam int STEP_W  = PROD_W - ALPHA_FRAC_BITS;
  localparam int SUM_W   = STEP_W + 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(200);
  localparam logic [TAU_W-1:0]     TAU_RST     = '0;
  localparam logic [DT_W-1:0]      DT_RST      = DT_W'(1000);

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_TAU     = 2'd1,
    CFG_DT      = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LATCH,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_FINISH
  } state_t;

endpackage

// ----- sv/vision_target_freshness_filter.sv -----
// Vision target freshness filter: latches new targets, checks their age and smooths
// both angles with a first-order low pass computed on one shared divide/multiply datapath.
// Depends on vtff_pkg.
//
//  channel | signals                                            | handshake
//  --------+----------------------------------------------------+--------------------
//  in      | in_tick_count in_frame_seq in_frame_ok in_pitch_in   | in_valid/in_ready
//          | in_yaw_in in_link_online                           |
//  out     | out_available out_filtered_pitch out_filtered_yaw  | out_valid/out_ready
//  cfg     | cfg_index cfg_data                                 | cfg_valid/cfg_ready
//
// When a filtering step runs, the restoring divider for alpha produces one quotient
// bit per cycle, then one multiplier serves pitch and yaw in turn.
// Reset clears all filter state; configuration returns to timeout 200, tau 0, dt 1000.
// The result sits in an output register, so the next input beat is taken while it waits;
// the sequencer stalls only at its end if the previous result is still not taken.
module vision_target_freshness_filter
  import vtff_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [TICK_W-1:0]         in_tick_count,
  input  logic [TICK_W-1:0]         in_frame_seq,
  input  logic                      in_frame_ok,
  input  logic signed [ANGLE_W-1:0] in_pitch_in,
  input  logic signed [ANGLE_W-1:0] in_yaw_in,
  input  logic                      in_link_online,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_available,
  output logic signed [ANGLE_W-1:0] out_filtered_pitch,
  output logic signed [ANGLE_W-1:0] out_filtered_yaw,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  state_t state_r, state_nxt;

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [TAU_W-1:0]     tau_r;
  logic [DT_W-1:0]      dt_r;

  logic [TICK_W-1:0]         now_r, now_nxt;
  logic [TICK_W-1:0]         seq_r, seq_nxt;
  logic                      tv_r, tv_nxt;
  logic signed [ANGLE_W-1:0] pin_r, pin_nxt;
  logic signed [ANGLE_W-1:0] yin_r, yin_nxt;
  logic                      online_r, online_nxt;

  logic [TICK_W-1:0]         last_seq_r, last_seq_nxt;
  logic [TICK_W-1:0]         last_tick_r, last_tick_nxt;
  logic signed [ANGLE_W-1:0] held_pitch_r, held_pitch_nxt;
  logic signed [ANGLE_W-1:0] held_yaw_r, held_yaw_nxt;
  logic signed [ANGLE_W-1:0] smooth_pitch_r, smooth_pitch_nxt;
  logic signed [ANGLE_W-1:0] smooth_yaw_r, smooth_yaw_nxt;
  logic                      has_target_r, has_target_nxt;
  logic                      tracking_r, tracking_nxt;
  logic                      avail_r, avail_nxt;

  logic [DIV_W-1:0]           div_r, div_nxt;
  logic [DIV_W-1:0]           rem_r, rem_nxt;
  logic [ALPHA_FRAC_BITS-1:0] alpha_r, alpha_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       axis_r, axis_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;

  logic                      ov_r, ov_nxt;
  logic                      oa_r, oa_nxt;
  logic signed [ANGLE_W-1:0] op_r, op_nxt;
  logic signed [ANGLE_W-1:0] oy_r, oy_nxt;

  logic [TICK_W-1:0]         age;
  logic                      avail_now;
  logic [DIV_W:0]            rem_sh;
  logic [DIV_W:0]            rem_sub;
  logic signed [ANGLE_W-1:0] held_sel;
  logic signed [ANGLE_W-1:0] smooth_sel;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [STEP_W-1:0]  step;
  logic signed [SUM_W-1:0]   sum;
  logic signed [ANGLE_W-1:0] sat;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (ALPHA_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]  SMAX = SUM_W'({1'b0, {(ANGLE_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0]  SMIN = -SMAX - SUM_W'(1);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_available      = oa_r;
  assign out_filtered_pitch = op_r;
  assign out_filtered_yaw   = oy_r;

  assign age       = now_r - last_tick_r;
  assign avail_now = has_target_r && online_r && (age <= TICK_W'(timeout_r));

  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {1'b0, div_r};

  assign held_sel   = axis_r ? held_yaw_r : held_pitch_r;
  assign smooth_sel = axis_r ? smooth_yaw_r : smooth_pitch_r;
  assign diff       = DIFF_W'(held_sel) - DIFF_W'(smooth_sel);
  assign prod_rnd   = prod_r + HALF;
  assign step       = STEP_W'(prod_rnd >>> ALPHA_FRAC_BITS);
  assign sum        = SUM_W'(smooth_sel) + SUM_W'(step);

  always_comb begin
    if (sum > SMAX) begin
      sat = {1'b0, {(ANGLE_W-1){1'b1}}};
    end else if (sum < SMIN) begin
      sat = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      sat = sum[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      tau_r     <= TAU_RST;
      dt_r      <= DT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_W-1:0];
        CFG_TAU:     tau_r     <= cfg_data[TAU_W-1:0];
        CFG_DT:      dt_r      <= cfg_data[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt        = state_r;
    now_nxt          = now_r;
    seq_nxt          = seq_r;
    tv_nxt           = tv_r;
    pin_nxt          = pin_r;
    yin_nxt          = yin_r;
    online_nxt       = online_r;
    last_seq_nxt     = last_seq_r;
    last_tick_nxt    = last_tick_r;
    held_pitch_nxt   = held_pitch_r;
    held_yaw_nxt     = held_yaw_r;
    smooth_pitch_nxt = smooth_pitch_r;
    smooth_yaw_nxt   = smooth_yaw_r;
    has_target_nxt   = has_target_r;
    tracking_nxt     = tracking_r;
    avail_nxt        = avail_r;
    div_nxt          = div_r;
    rem_nxt          = rem_r;
    alpha_nxt        = alpha_r;
    cnt_nxt          = cnt_r;
    axis_nxt         = axis_r;
    prod_nxt         = prod_r;
    ov_nxt           = ov_r;
    oa_nxt           = oa_r;
    op_nxt           = op_r;
    oy_nxt           = oy_r;

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt    = in_tick_count;
          seq_nxt    = in_frame_seq;
          tv_nxt     = in_frame_ok;
          pin_nxt    = in_pitch_in;
          yin_nxt    = in_yaw_in;
          online_nxt = in_link_online;
          state_nxt  = ST_LATCH;
        end
      end
      ST_LATCH: begin
        if (seq_r != last_seq_r) begin
          last_seq_nxt = seq_r;
          if (tv_r) begin
            held_pitch_nxt = pin_r;
            held_yaw_nxt   = yin_r;
            last_tick_nxt  = now_r;
            has_target_nxt = 1'b1;
          end
        end
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        avail_nxt = avail_now;
        state_nxt = ST_FINISH;
        if (!avail_now) begin
          tracking_nxt = 1'b0;
        end else if (!tracking_r || tau_r == '0) begin
          smooth_pitch_nxt = held_pitch_r;
          smooth_yaw_nxt   = held_yaw_r;
          tracking_nxt     = 1'b1;
        end else begin
          div_nxt   = DIV_W'(tau_r) + DIV_W'(dt_r);
          rem_nxt   = DIV_W'(dt_r);
          alpha_nxt = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!rem_sub[DIV_W]) begin
          rem_nxt   = rem_sub[DIV_W-1:0];
          alpha_nxt = {alpha_r[ALPHA_FRAC_BITS-2:0], 1'b1};
        end else begin
          rem_nxt   = rem_sh[DIV_W-1:0];
          alpha_nxt = {alpha_r[ALPHA_FRAC_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ALPHA_FRAC_BITS - 1)) begin
          axis_nxt  = 1'b0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'($signed({1'b0, alpha_r}) * diff);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (axis_r) begin
          smooth_yaw_nxt = sat;
          state_nxt      = ST_FINISH;
        end else begin
          smooth_pitch_nxt = sat;
          axis_nxt         = 1'b1;
          state_nxt        = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oa_nxt    = avail_r;
          op_nxt    = smooth_pitch_r;
          oy_nxt    = smooth_yaw_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_seq_r     <= '0;
      last_tick_r    <= '0;
      held_pitch_r   <= '0;
      held_yaw_r     <= '0;
      smooth_pitch_r <= '0;
      smooth_yaw_r   <= '0;
      has_target_r   <= 1'b0;
      tracking_r     <= 1'b0;
      ov_r           <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      last_seq_r     <= last_seq_nxt;
      last_tick_r    <= last_tick_nxt;
      held_pitch_r   <= held_pitch_nxt;
      held_yaw_r     <= held_yaw_nxt;
      smooth_pitch_r <= smooth_pitch_nxt;
      smooth_yaw_r   <= smooth_yaw_nxt;
      has_target_r   <= has_target_nxt;
      tracking_r     <= tracking_nxt;
      ov_r           <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r    <= now_nxt;
    seq_r    <= seq_nxt;
    tv_r     <= tv_nxt;
    pin_r    <= pin_nxt;
    yin_r    <= yin_nxt;
    online_r <= online_nxt;
    avail_r  <= avail_nxt;
    div_r    <= div_nxt;
    rem_r    <= rem_nxt;
    alpha_r  <= alpha_nxt;
    cnt_r    <= cnt_nxt;
    axis_r   <= axis_nxt;
    prod_r   <= prod_nxt;
    oa_r     <= oa_nxt;
    op_r     <= op_nxt;
    oy_r     <= oy_nxt;
  end

endmodule

// ----- sv/vtff_checker.sv -----
// Port-level checks for the vision target freshness filter.
// Bound to vision_target_freshness_filter; depends on vtff_pkg.
module vtff_checker
  import vtff_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_available,
  input logic signed [ANGLE_W-1:0] out_filtered_pitch,
  input logic signed [ANGLE_W-1:0] out_filtered_yaw,
  input logic                      cfg_valid,
  input logic                      cfg_ready
);

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon after a beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_available)
      && $stable(out_filtered_pitch) && $stable(out_filtered_yaw))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset left a result or busy state");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind vision_target_freshness_filter vtff_checker u_vtff_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_available      (out_available),
  .out_filtered_pitch (out_filtered_pitch),
  .out_filtered_yaw   (out_filtered_yaw),
  .cfg_valid          (cfg_valid),
  .cfg_ready          (cfg_ready)
);
